[rtl/core/rvd_pkg.sv]
// Shared types, codes and lookup functions of the RV32I instruction decoder.
`default_nettype none

package rvd_pkg;

	// Major opcodes of the base integer set that the decoder handles.
	localparam logic [6:0] OPC_LUI    = 7'b0110111;
	localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
	localparam logic [6:0] OPC_JAL    = 7'b1101111;
	localparam logic [6:0] OPC_JALR   = 7'b1100111;
	localparam logic [6:0] OPC_BRANCH = 7'b1100011;
	localparam logic [6:0] OPC_LOAD   = 7'b0000011;
	localparam logic [6:0] OPC_STORE  = 7'b0100011;
	localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
	localparam logic [6:0] OPC_OP     = 7'b0110011;
	localparam logic [6:0] OPC_FENCE  = 7'b0001111;

	// Mask that keeps the upper immediate of the U layout.
	localparam logic [31:0] UPPER_MASK = 32'hFFFF_F000;

	// funct3 values that need special handling.
	localparam logic [2:0] F3_ADD_SUB = 3'b000;
	localparam logic [2:0] F3_SHR     = 3'b101;

	// Instruction class chosen by the opcode.
	typedef enum logic [3:0] {
		CLS_LUI,
		CLS_AUIPC,
		CLS_JAL,
		CLS_JALR,
		CLS_BRANCH,
		CLS_LOAD,
		CLS_STORE,
		CLS_OPIMM,
		CLS_OP,
		CLS_FENCE,
		CLS_NONE
	} cls_t;

	// Decoded operation codes.
	typedef enum logic [5:0] {
		OP_LUI, OP_AUIPC, OP_JAL, OP_JALR,
		OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU,
		OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU,
		OP_SB, OP_SH, OP_SW,
		OP_ADDI, OP_SLTI, OP_SLTIU, OP_XORI, OP_ORI, OP_ANDI,
		OP_SLLI, OP_SRLI, OP_SRAI,
		OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_SRA,
		OP_OR, OP_AND,
		OP_FENCE, OP_FENCEI,
		OP_UNKNOWN
	} op_t;

	// Register and function fields decoded in the second stage.
	typedef struct packed {
		op_t        op;
		logic [4:0] rd;
		logic [4:0] rs1;
		logic [4:0] rs2;
		logic [2:0] f3;
		logic [6:0] f7;
	} dec_t;

	// Class of an opcode.
	function automatic cls_t opcode_class(input logic [6:0] opc);
		cls_t c;
		unique case (opc)
			OPC_LUI:    c = CLS_LUI;
			OPC_AUIPC:  c = CLS_AUIPC;
			OPC_JAL:    c = CLS_JAL;
			OPC_JALR:   c = CLS_JALR;
			OPC_BRANCH: c = CLS_BRANCH;
			OPC_LOAD:   c = CLS_LOAD;
			OPC_STORE:  c = CLS_STORE;
			OPC_OPIMM:  c = CLS_OPIMM;
			OPC_OP:     c = CLS_OP;
			OPC_FENCE:  c = CLS_FENCE;
			default:    c = CLS_NONE;
		endcase
		return c;
	endfunction

	// Conditional branches by funct3.
	function automatic op_t branch_op(input logic [2:0] f3);
		op_t o;
		unique case (f3)
			3'd0:    o = OP_BEQ;
			3'd1:    o = OP_BNE;
			3'd4:    o = OP_BLT;
			3'd5:    o = OP_BGE;
			3'd6:    o = OP_BLTU;
			3'd7:    o = OP_BGEU;
			default: o = OP_UNKNOWN;
		endcase
		return o;
	endfunction

	// Loads by funct3.
	function automatic op_t load_op(input logic [2:0] f3);
		op_t o;
		unique case (f3)
			3'd0:    o = OP_LB;
			3'd1:    o = OP_LH;
			3'd2:    o = OP_LW;
			3'd4:    o = OP_LBU;
			3'd5:    o = OP_LHU;
			default: o = OP_UNKNOWN;
		endcase
		return o;
	endfunction

	// Stores by funct3.
	function automatic op_t store_op(input logic [2:0] f3);
		op_t o;
		unique case (f3)
			3'd0:    o = OP_SB;
			3'd1:    o = OP_SH;
			3'd2:    o = OP_SW;
			default: o = OP_UNKNOWN;
		endcase
		return o;
	endfunction

	// Register-immediate operations; funct7 picks between the right shifts.
	function automatic op_t opimm_op(input logic [2:0] f3, input logic f7_any);
		op_t o;
		unique case (f3)
			3'd0:    o = OP_ADDI;
			3'd1:    o = OP_SLLI;
			3'd2:    o = OP_SLTI;
			3'd3:    o = OP_SLTIU;
			3'd4:    o = OP_XORI;
			3'd5:    o = f7_any ? OP_SRAI : OP_SRLI;
			3'd6:    o = OP_ORI;
			default: o = OP_ANDI;
		endcase
		return o;
	endfunction

	// Register-register operations; any nonzero funct7 selects SUB or SRA.
	function automatic op_t reg_op(input logic [2:0] f3, input logic f7_any);
		op_t o;
		unique case (f3)
			3'd0:    o = f7_any ? OP_SUB : OP_ADD;
			3'd1:    o = OP_SLL;
			3'd2:    o = OP_SLT;
			3'd3:    o = OP_SLTU;
			3'd4:    o = OP_XOR;
			3'd5:    o = f7_any ? OP_SRA : OP_SRL;
			3'd6:    o = OP_OR;
			default: o = OP_AND;
		endcase
		return o;
	endfunction

	// Fence instructions by funct3.
	function automatic op_t fence_op(input logic [2:0] f3);
		op_t o;
		unique case (f3)
			3'd0:    o = OP_FENCE;
			3'd1:    o = OP_FENCEI;
			default: o = OP_UNKNOWN;
		endcase
		return o;
	endfunction

endpackage

`default_nettype wire

[rtl/core/rv32i_instruction_decoder.sv]
// Top level of the three-stage RV32I instruction decoder.
//
//   Channel   Handshake            Payload
//   command   start, busy          instruction_word
//   result    done (one cycle)     operation, dest_reg, src1_reg, src2_reg,
//                                  minor_op, major_variant, raw_immediate,
//                                  signed_immediate
//
// A transaction is taken at every edge with start high; busy is always low.
// The result leaves the last stage register, marked by done for one cycle.
// Stages: opcode class, operation and register fields, immediates.
// One transaction per cycle is sustained; the stage depth sets the latency.
// Reset clears only the valid bits; the receiver cannot stall the block.
`default_nettype none

module rv32i_instruction_decoder
	import rvd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [31:0]        instruction_word,
	output logic                    done,
	output logic [5:0]              operation,
	output logic [4:0]              dest_reg,
	output logic [4:0]              src1_reg,
	output logic [4:0]              src2_reg,
	output logic [2:0]              minor_op,
	output logic [6:0]              major_variant,
	output logic [31:0]             raw_immediate,
	output logic signed [31:0]      signed_immediate
);

	logic        in_valid;
	logic        valid_s1;
	logic [31:0] word_s1;
	cls_t        cls_s1;
	logic        valid_s2;
	logic [31:0] word_s2;
	cls_t        cls_s2;
	dec_t        dec_s2;
	logic        valid_s3;
	dec_t        dec_s3;
	logic [31:0] raw_s3;
	logic [31:0] simm_s3;

	// Every stage advances each cycle, so a new command is always welcome.
	assign busy     = 1'b0;
	assign in_valid = start && !busy;

	rvd_class u_class (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_word  (instruction_word),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1),
		.cls_s1   (cls_s1)
	);

	rvd_fields u_fields (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1),
		.cls_s1   (cls_s1),
		.valid_s2 (valid_s2),
		.word_s2  (word_s2),
		.cls_s2   (cls_s2),
		.dec_s2   (dec_s2)
	);

	rvd_imm u_imm (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.word_s2  (word_s2),
		.cls_s2   (cls_s2),
		.dec_s2   (dec_s2),
		.valid_s3 (valid_s3),
		.dec_s3   (dec_s3),
		.raw_s3   (raw_s3),
		.simm_s3  (simm_s3)
	);

	// Result ports come straight from the last stage registers.
	assign done             = valid_s3;
	assign operation        = dec_s3.op;
	assign dest_reg         = dec_s3.rd;
	assign src1_reg         = dec_s3.rs1;
	assign src2_reg         = dec_s3.rs2;
	assign minor_op         = dec_s3.f3;
	assign major_variant    = dec_s3.f7;
	assign raw_immediate    = raw_s3;
	assign signed_immediate = simm_s3;

`ifndef SYNTHESIS
	// Each result stems from a command that passed through every stage.
	a_done_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result without a matching command");

	// Every command yields a result; none is lost in the pipeline.
	a_cmd_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("command lost in the pipeline");

	// funct7 is passed on only for register-register operations.
	a_f7_reg_only: assert property (@(posedge clk) disable iff (!arst_n)
		(done && major_variant != 7'd0) |->
		(operation >= OP_ADD && operation <= OP_AND))
		else $error("funct7 given for a non register-register operation");

	// Sign extension never changes the low bits of the immediate.
	a_imm_low_bits: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (signed_immediate[4:0] == raw_immediate[4:0]))
		else $error("immediates disagree in their low bits");
`endif

endmodule

`default_nettype wire

[rtl/core/rvd_class.sv]
// First stage: captures the instruction word and classifies its opcode.
`default_nettype none

module rvd_class
	import rvd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic [31:0] in_word,
	output logic             valid_s1,
	output logic [31:0]      word_s1,
	output cls_t             cls_s1
);

	// Valid bit of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	// Word and its class travel together.
	always_ff @(posedge clk) begin
		word_s1 <= in_word;
		cls_s1  <= opcode_class(in_word[6:0]);
	end

endmodule

`default_nettype wire

[rtl/core/rvd_fields.sv]
// Second stage: decodes the operation and the register and function fields.
`default_nettype none

module rvd_fields
	import rvd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        valid_s1,
	input  wire logic [31:0] word_s1,
	input  cls_t             cls_s1,
	output logic             valid_s2,
	output logic [31:0]      word_s2,
	output cls_t             cls_s2,
	output dec_t             dec_s2
);

	logic [2:0] f3;
	logic [6:0] f7;
	logic       f7_any;
	dec_t       dec;

	assign f3     = word_s1[14:12];
	assign f7     = word_s1[31:25];
	assign f7_any = |f7;

	// Operation and the fields that the layout uses; the rest stay zero.
	always_comb begin
		dec = '{op: OP_UNKNOWN, rd: 5'd0, rs1: 5'd0, rs2: 5'd0, f3: 3'd0, f7: 7'd0};
		unique case (cls_s1)
			CLS_LUI, CLS_AUIPC: begin
				dec.op = (cls_s1 == CLS_LUI) ? OP_LUI : OP_AUIPC;
				dec.rd = word_s1[11:7];
			end
			CLS_JAL: begin
				dec.op = OP_JAL;
				dec.rd = word_s1[11:7];
			end
			CLS_JALR, CLS_LOAD, CLS_OPIMM, CLS_FENCE: begin
				dec.rd  = word_s1[11:7];
				dec.rs1 = word_s1[19:15];
				dec.f3  = f3;
				unique case (cls_s1)
					CLS_JALR:  dec.op = OP_JALR;
					CLS_LOAD:  dec.op = load_op(f3);
					CLS_OPIMM: dec.op = opimm_op(f3, f7_any);
					default:   dec.op = fence_op(f3);
				endcase
			end
			CLS_BRANCH, CLS_STORE: begin
				dec.rs1 = word_s1[19:15];
				dec.rs2 = word_s1[24:20];
				dec.f3  = f3;
				dec.op  = (cls_s1 == CLS_BRANCH) ? branch_op(f3) : store_op(f3);
			end
			CLS_OP: begin
				dec.rd  = word_s1[11:7];
				dec.rs1 = word_s1[19:15];
				dec.rs2 = word_s1[24:20];
				dec.f3  = f3;
				dec.f7  = f7;
				dec.op  = reg_op(f3, f7_any);
			end
			default: begin
				dec.op = OP_UNKNOWN;
			end
		endcase
	end

	// Valid bit of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		word_s2 <= word_s1;
		cls_s2  <= cls_s1;
		dec_s2  <= dec;
	end

endmodule

`default_nettype wire

[rtl/core/rvd_imm.sv]
// Third stage: assembles the immediates and holds the result registers.
`default_nettype none

module rvd_imm
	import rvd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        valid_s2,
	input  wire logic [31:0] word_s2,
	input  cls_t             cls_s2,
	input  dec_t             dec_s2,
	output logic             valid_s3,
	output dec_t             dec_s3,
	output logic [31:0]      raw_s3,
	output logic [31:0]      simm_s3
);

	logic [31:0] raw;
	logic [31:0] simm;
	logic        sgn;

	assign sgn = word_s2[31];

	// Immediate of the layout chosen by the class.
	always_comb begin
		raw  = 32'd0;
		simm = 32'd0;
		unique case (cls_s2)
			CLS_LUI, CLS_AUIPC: begin
				raw  = word_s2 & UPPER_MASK;
				simm = word_s2 & UPPER_MASK;
			end
			CLS_JAL: begin
				raw  = {11'd0, word_s2[31], word_s2[19:12], word_s2[20],
					word_s2[30:21], 1'b0};
				simm = {{11{sgn}}, word_s2[31], word_s2[19:12], word_s2[20],
					word_s2[30:21], 1'b0};
			end
			CLS_JALR, CLS_LOAD, CLS_OPIMM, CLS_FENCE: begin
				simm = {{20{sgn}}, word_s2[31:20]};
				// For right shifts by immediate, the raw immediate keeps only the shift amount.
				if (dec_s2.op == OP_SRLI || dec_s2.op == OP_SRAI) begin
					raw = {27'd0, word_s2[24:20]};
				end else begin
					raw = {20'd0, word_s2[31:20]};
				end
			end
			CLS_BRANCH: begin
				raw  = {19'd0, word_s2[31], word_s2[7], word_s2[30:25],
					word_s2[11:8], 1'b0};
				simm = {{19{sgn}}, word_s2[31], word_s2[7], word_s2[30:25],
					word_s2[11:8], 1'b0};
			end
			CLS_STORE: begin
				raw  = {20'd0, word_s2[31:25], word_s2[11:7]};
				simm = {{20{sgn}}, word_s2[31:25], word_s2[11:7]};
			end
			default: begin
				raw  = 32'd0;
				simm = 32'd0;
			end
		endcase
	end

	// Valid bit of the result stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		dec_s3  <= dec_s2;
		raw_s3  <= raw;
		simm_s3 <= simm;
	end

endmodule

`default_nettype wire
